[rtl/core/frx_pkg.sv]
// Package for the framed stream receiver: header layout, message and phase
// codes, run status codes, the request stage struct and the byte-wide CRC-32 step.
// No dependencies.
`default_nettype none

package frx_pkg;

   localparam logic [31:0] FRAME_MAGIC = 32'h5442_5031;
   localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

   // Header byte offsets (the header is 52 bytes, positions 0 to 51).
   localparam logic [5:0] LAST_HDR_POS = 6'd51;
   localparam logic [5:0] MAGIC_OFS    = 6'd0;
   localparam logic [5:0] TYPE_OFS     = 6'd8;
   localparam logic [5:0] LEN_OFS      = 6'd16;
   localparam logic [5:0] CHECK_OFS    = 6'd48;

   localparam logic [15:0] MSG_HELLO         = 16'd1;
   localparam logic [15:0] MSG_SESSION_START = 16'd3;
   localparam logic [15:0] MSG_SEG_BEGIN     = 16'd7;
   localparam logic [15:0] MSG_CHUNK         = 16'd8;
   localparam logic [15:0] MSG_SEG_END       = 16'd9;
   localparam logic [15:0] MSG_DONE          = 16'd12;

   localparam logic [2:0] PH_HELLO     = 3'd0;
   localparam logic [2:0] PH_SESSION   = 3'd1;
   localparam logic [2:0] PH_SEG_BEGIN = 3'd2;
   localparam logic [2:0] PH_CHUNKS    = 3'd3;
   localparam logic [2:0] PH_WAIT_DONE = 3'd4;

   localparam logic [1:0] ST_BUSY      = 2'd0;
   localparam logic [1:0] ST_COMPLETE  = 2'd1;
   localparam logic [1:0] ST_BAD_MAGIC = 2'd2;
   localparam logic [1:0] ST_CRC_ERROR = 2'd3;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } frx_stage_type;

   // One byte of reflected CRC-32, bit by bit.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[rtl/core/framed_stream_receiver.sv]
// Framed stream receiver: one received byte in per request, one result per byte
// out; a 52-byte little-endian header parser, payload CRC-32 check and the session
// phase machine. Depends on frx_pkg, frx_in_stage and frx_parse.
//
// Each request carries one byte of the link stream and produces exactly one
// response, in order. The block sustains one request per clock cycle while
// responses are not stalled; a request is accepted into the request register
// and then moves into the result register, where its response is presented.
// The longest path is the byte-wide CRC-32 update (eight chained shift-and-XOR
// steps) followed by a 32-bit compare against the header's check word.
// req_stall is high only while the request register holds a byte and the
// result register holds a stalled response, so it follows rsp_stall within
// the same cycle; while the request register is empty, one more byte is
// still taken behind a waiting response. The response carries the
// chunk payload byte (out_valid set only for chunk frames in the chunk phase),
// the run status after that byte, the count of accepted chunk frames and a
// frame end flag. Once the run has ended (complete, bad magic or CRC mismatch)
// every further byte is answered with an idle response carrying the final
// status until reset. Note that a chunk frame whose CRC fails has already had
// its bytes passed out, so the consumer must discard the transfer when it sees
// the CRC mismatch status. The single control register (payload CRC check
// enable, set after reset) is written through csr_wr_en and csr_wr_data and
// must only be changed while the block is idle.
`default_nettype none

module framed_stream_receiver
   import frx_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [7:0]  rsp_out_byte,
   output      logic        rsp_out_valid,
   output      logic [1:0]  rsp_run_status,
   output      logic [31:0] rsp_chunk_count,
   output      logic        rsp_frame_end,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);

   frx_stage_type stage;
   logic          advance;

   // Request register: decouples the link from the result register.
   frx_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .stage       (stage)
   );

   // All per-byte work happens here, between the request register and the
   // result register.
   frx_parse u_parse (
      .clock           (clock),
      .reset           (reset),
      .stage           (stage),
      .advance         (advance),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_valid   (rsp_out_valid),
      .rsp_run_status  (rsp_run_status),
      .rsp_chunk_count (rsp_chunk_count),
      .rsp_frame_end   (rsp_frame_end)
   );

   // Input is only held back when the result register is full and stalled.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled while the result register could drain");

   // A response without a chunk byte carries a zero byte.
   a_idle_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_valid) |-> (rsp_out_byte == 8'd0))
      else $error("non-chunk response carries a data byte");

   // A chunk byte that does not end its frame is only passed while the run is busy.
   a_chunk_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_valid && !rsp_frame_end) |-> (rsp_run_status == ST_BUSY))
      else $error("chunk byte passed after the run ended");

endmodule

`default_nettype wire

[rtl/core/frx_in_stage.sv]
// Request register of the framed stream receiver: holds one received byte
// until the parse stage takes it. Depends on frx_pkg.
`default_nettype none

module frx_in_stage
   import frx_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_stall,
   input  wire logic [7:0]    req_rx_byte,
   input  wire logic          advance,
   output      frx_stage_type stage
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;

   // The register is free when empty or when its request moves on this cycle.
   assign req_stall = valid_ff && !advance;

   always_comb begin
      valid_in = valid_ff && !advance;
      byte_in  = byte_ff;
      if (!req_stall) begin
         valid_in = req_valid;
         byte_in  = req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign stage.valid   = valid_ff;
   assign stage.rx_byte = byte_ff;

endmodule

`default_nettype wire

[rtl/core/frx_parse.sv]
// Parse stage of the framed stream receiver: header capture, payload count,
// CRC-32, session phase machine and the result register. Depends on frx_pkg.
`default_nettype none

module frx_parse
   import frx_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire frx_stage_type stage,
   output      logic          advance,
   input  wire logic          csr_wr_en,
   input  wire logic          csr_wr_data,
   output      logic          rsp_valid,
   input  wire logic          rsp_stall,
   output      logic [7:0]    rsp_out_byte,
   output      logic          rsp_out_valid,
   output      logic [1:0]    rsp_run_status,
   output      logic [31:0]   rsp_chunk_count,
   output      logic          rsp_frame_end
);

   logic        check_crc_ff;
   logic [5:0]  hdr_pos_ff, hdr_pos_in;
   logic        in_payload_ff, in_payload_in;
   logic [31:0] magic_ff, magic_in;
   logic [15:0] msg_type_ff, msg_type_in;
   logic [31:0] bytes_left_ff, bytes_left_in;
   logic [31:0] expected_ff, expected_in;
   logic [31:0] crc_ff, crc_in;
   logic [2:0]  phase_ff, phase_in;
   logic [31:0] chunks_ff, chunks_in;
   logic [1:0]  status_ff, status_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_valid_ff, out_valid_in;
   logic        frame_end_ff, frame_end_in;

   logic [7:0]  b;
   logic [1:0]  lane;
   logic [31:0] crc_next;
   logic        do_apply;

   assign b        = stage.rx_byte;
   assign lane     = hdr_pos_ff[1:0];
   assign crc_next = crc_byte(crc_ff, b);

   // The result register drains or is empty: the held request can move.
   assign advance = stage.valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      hdr_pos_in    = hdr_pos_ff;
      in_payload_in = in_payload_ff;
      magic_in      = magic_ff;
      msg_type_in   = msg_type_ff;
      bytes_left_in = bytes_left_ff;
      expected_in   = expected_ff;
      crc_in        = crc_ff;
      phase_in      = phase_ff;
      chunks_in     = chunks_ff;
      status_in     = status_ff;
      out_byte_in   = 8'd0;
      out_valid_in  = 1'b0;
      frame_end_in  = 1'b0;
      do_apply      = 1'b0;

      if (status_ff == ST_BUSY) begin
         if (!in_payload_ff) begin
            if (hdr_pos_ff < MAGIC_OFS + 6'd4) begin
               magic_in[8*lane +: 8] = b;
            end else if (hdr_pos_ff >= TYPE_OFS && hdr_pos_ff < TYPE_OFS + 6'd2) begin
               msg_type_in[8*lane[0] +: 8] = b;
            end else if (hdr_pos_ff >= LEN_OFS && hdr_pos_ff < LEN_OFS + 6'd4) begin
               bytes_left_in[8*lane +: 8] = b;
            end else if (hdr_pos_ff >= CHECK_OFS) begin
               expected_in[8*lane +: 8] = b;
            end

            if (hdr_pos_ff == LAST_HDR_POS) begin
               hdr_pos_in = 6'd0;
               if (magic_ff != FRAME_MAGIC) begin
                  status_in     = ST_BAD_MAGIC;
                  frame_end_in  = 1'b1;
                  bytes_left_in = 32'd0;
                  crc_in        = CRC_INIT;
               end else if (bytes_left_ff == 32'd0) begin
                  frame_end_in = 1'b1;
                  do_apply     = 1'b1;
                  crc_in       = CRC_INIT;
               end else begin
                  in_payload_in = 1'b1;
                  crc_in        = CRC_INIT;
               end
            end else begin
               hdr_pos_in = hdr_pos_ff + 6'd1;
            end
         end else begin
            crc_in        = crc_next;
            bytes_left_in = bytes_left_ff - 32'd1;
            if (msg_type_ff == MSG_CHUNK && phase_ff == PH_CHUNKS) begin
               out_byte_in  = b;
               out_valid_in = 1'b1;
            end
            if (bytes_left_ff == 32'd1) begin
               frame_end_in  = 1'b1;
               hdr_pos_in    = 6'd0;
               in_payload_in = 1'b0;
               crc_in        = CRC_INIT;
               if (check_crc_ff && ~crc_next != expected_ff) begin
                  status_in = ST_CRC_ERROR;
               end else begin
                  do_apply = 1'b1;
               end
            end
         end
      end

      // Session phase machine, advanced by a frame that ends cleanly.
      if (do_apply) begin
         unique case (msg_type_ff)
            MSG_HELLO: begin
               if (phase_ff == PH_HELLO) phase_in = PH_SESSION;
            end
            MSG_SESSION_START: begin
               if (phase_ff == PH_SESSION) phase_in = PH_SEG_BEGIN;
            end
            MSG_SEG_BEGIN: begin
               if (phase_ff == PH_SEG_BEGIN) phase_in = PH_CHUNKS;
            end
            MSG_CHUNK: begin
               if (phase_ff == PH_CHUNKS) chunks_in = chunks_ff + 32'd1;
            end
            MSG_SEG_END: begin
               if (phase_ff == PH_CHUNKS) phase_in = PH_WAIT_DONE;
            end
            MSG_DONE: begin
               status_in = ST_COMPLETE;
            end
            default: begin
            end
         endcase
      end

      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_crc_ff  <= 1'b1;
         hdr_pos_ff    <= 6'd0;
         in_payload_ff <= 1'b0;
         magic_ff      <= 32'd0;
         msg_type_ff   <= 16'd0;
         bytes_left_ff <= 32'd0;
         expected_ff   <= 32'd0;
         crc_ff        <= CRC_INIT;
         phase_ff      <= PH_HELLO;
         chunks_ff     <= 32'd0;
         status_ff     <= ST_BUSY;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            check_crc_ff <= csr_wr_data;
         end
         if (advance) begin
            hdr_pos_ff    <= hdr_pos_in;
            in_payload_ff <= in_payload_in;
            magic_ff      <= magic_in;
            msg_type_ff   <= msg_type_in;
            bytes_left_ff <= bytes_left_in;
            expected_ff   <= expected_in;
            crc_ff        <= crc_in;
            phase_ff      <= phase_in;
            chunks_ff     <= chunks_in;
            status_ff     <= status_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_byte_ff  <= out_byte_in;
         out_valid_ff <= out_valid_in;
         frame_end_ff <= frame_end_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_out_valid   = out_valid_ff;
   assign rsp_run_status  = status_ff;
   assign rsp_chunk_count = chunks_ff;
   assign rsp_frame_end   = frame_end_ff;

endmodule

`default_nettype wire
